### hdl/dlp_pkg.sv
// Package for the DAG longest-path core: payload structs, sizes and shared constants.
// No dependencies.
`timescale 1ns / 1ps
package dlp_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxEdges    = 4096;
  localparam int VidW        = 10;
  localparam int PathW       = 10;
  localparam int CountW      = 11;
  localparam logic [PathW-1:0] PathCap = 10'd1023;

  typedef struct packed {
    logic            edge_valid;
    logic [VidW-1:0] from_vertex;
    logic [VidW-1:0] to_vertex;
    logic            is_last;
  } in_item_t;

  typedef struct packed {
    logic [PathW-1:0] longest_path;
    logic             cycle_found;
    logic             edges_dropped;
  } out_item_t;
endpackage

### hdl/dlp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module dlp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/dag_longest_path_core.sv
// Top level of the DAG longest-path core: edge loading, Kahn ordering and relaxation.
// Depends on dlp_pkg and dlp_ram.
`timescale 1ns / 1ps
// Edges are taken one beat per cycle into an edge store until the beat marked last,
// except that the last beat is held while a result still waits. The core then stops
// accepting beats and walks the graph with one sequencer and memories of one write and
// one read port each: a clearing pass over the per-vertex stores, an in-degree count
// per edge, a prefix sum per vertex, a bucketing pass per edge, a ready scan per
// vertex, a walk over each ordered vertex and its successor edges, and a maximum scan
// per vertex. One result beat follows; it waits in an output register and the next
// graph may load while it is stalled, up to its last beat.
module dag_longest_path_core #(
  parameter int MAX_VERTICES = dlp_pkg::MaxVertices,
  parameter int MAX_EDGES    = dlp_pkg::MaxEdges
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dlp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dlp_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int VW = dlp_pkg::VidW;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int OW = $clog2(MAX_VERTICES + 1);
  localparam int EW = $clog2(MAX_EDGES);
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int PW = dlp_pkg::PathW;
  localparam int CW = dlp_pkg::CountW;

  localparam logic [1:0] RegVertexCount = 2'd0;

  localparam logic [4:0]
    S_LOAD = 5'd0,  S_CLR = 5'd1,  S_DG_RD = 5'd2, S_DG_WT = 5'd3, S_DG_UP = 5'd4,
    S_PS_RD = 5'd5, S_PS_WR = 5'd6, S_BK_RD = 5'd7, S_BK_WT = 5'd8, S_BK_UP = 5'd9,
    S_RS_RD = 5'd10, S_RS_CK = 5'd11, S_POP = 5'd12, S_POP_WT = 5'd13,
    S_OFF = 5'd14, S_OFF_WT = 5'd15, S_E_RD = 5'd16, S_E_WT = 5'd17,
    S_W_RD = 5'd18, S_W_WT = 5'd19, S_W_UP = 5'd20, S_MX_RD = 5'd21,
    S_MX_CK = 5'd22, S_DONE = 5'd23, S_OFF2 = 5'd24, S_POP2 = 5'd25;

  logic [4:0]     state_r, state_nxt;
  logic [CW-1:0]  vcount_r;
  logic [ECW-1:0] etotal_r;
  logic           ovf_r;
  logic [OW:0]    n_eff;
  logic [OW:0]    idx_r;
  logic [ECW-1:0] eidx_r, eend_r;
  logic [EW:0]    acc_r;
  logic [OW:0]    sp_r, ord_r;
  logic [VW-1:0]  u_r, w_r;
  logic [PW-1:0]  cand_r, best_r;
  logic           out_valid_r;
  dlp_pkg::out_item_t out_r;

  // memory ports
  logic           es_we;  logic [EW-1:0] es_wa, es_ra; logic [2*VW-1:0] es_wd, es_rd;
  logic           dg_we;  logic [AW-1:0] dg_wa, dg_ra; logic [EW:0] dg_wd, dg_rd;
  logic           of_we;  logic [OW-1:0] of_wa, of_ra; logic [EW:0] of_wd, of_rd;
  logic           st_we;  logic [EW-1:0] st_wa, st_ra; logic [VW-1:0] st_wd, st_rd;
  logic           pl_we;  logic [AW-1:0] pl_wa, pl_ra; logic [PW-1:0] pl_wd, pl_rd;
  logic           rs_we;  logic [AW-1:0] rs_wa, rs_ra; logic [VW-1:0] rs_wd, rs_rd;

  dlp_ram #(.Width(2*VW), .Depth(MAX_EDGES)) u_edges (.clk, .we(es_we), .waddr(es_wa),
    .wdata(es_wd), .raddr(es_ra), .rdata(es_rd));
  dlp_ram #(.Width(EW+1), .Depth(MAX_VERTICES)) u_indeg (.clk, .we(dg_we), .waddr(dg_wa),
    .wdata(dg_wd), .raddr(dg_ra), .rdata(dg_rd));
  dlp_ram #(.Width(EW+1), .Depth(MAX_VERTICES+1)) u_offs (.clk, .we(of_we), .waddr(of_wa),
    .wdata(of_wd), .raddr(of_ra), .rdata(of_rd));
  dlp_ram #(.Width(VW), .Depth(MAX_EDGES)) u_targ (.clk, .we(st_we), .waddr(st_wa),
    .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
  dlp_ram #(.Width(PW), .Depth(MAX_VERTICES)) u_plen (.clk, .we(pl_we), .waddr(pl_wa),
    .wdata(pl_wd), .raddr(pl_ra), .rdata(pl_rd));
  dlp_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_stack (.clk, .we(rs_we), .waddr(rs_wa),
    .wdata(rs_wd), .raddr(rs_ra), .rdata(rs_rd));

  logic in_acc, out_acc, cfg_wr;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = (paddr == RegVertexCount) ? {{(32-CW){1'b0}}, vcount_r} : 32'd0;
  // The final beat needs the output register free, so hold off if it still waits.
  assign in_stall = (state_r != S_LOAD) || (out_valid_r && in_data.is_last);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    if (vcount_r == '0) n_eff = (OW+1)'(1);
    else if (32'(vcount_r) > MAX_VERTICES) n_eff = (OW+1)'(MAX_VERTICES);
    else n_eff = (OW+1)'(vcount_r);
  end

  logic [VW-1:0] ef, et;
  logic          e_ok;
  assign ef   = es_rd[2*VW-1:VW];
  assign et   = es_rd[VW-1:0];
  assign e_ok = ((OW+1)'(ef) < n_eff) && ((OW+1)'(et) < n_eff);

  logic [OW:0] idx_nxt, sp_nxt, ord_nxt;
  logic [ECW-1:0] eidx_nxt, eend_nxt, etotal_nxt;
  logic [EW:0] acc_nxt;
  logic [VW-1:0] u_nxt, w_nxt;
  logic [PW-1:0] cand_nxt, best_nxt;
  logic ovf_nxt, ov_nxt;
  dlp_pkg::out_item_t out_nxt;

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; eidx_nxt = eidx_r; eend_nxt = eend_r;
    acc_nxt = acc_r; sp_nxt = sp_r; ord_nxt = ord_r; u_nxt = u_r; w_nxt = w_r;
    cand_nxt = cand_r; best_nxt = best_r; etotal_nxt = etotal_r; ovf_nxt = ovf_r;
    out_nxt = out_r; ov_nxt = out_valid_r && !out_acc;
    es_we = 1'b0; es_wa = EW'(etotal_r); es_wd = {in_data.from_vertex, in_data.to_vertex};
    es_ra = EW'(eidx_r);
    dg_we = 1'b0; dg_wa = AW'(idx_r); dg_wd = '0; dg_ra = AW'(idx_r);
    of_we = 1'b0; of_wa = OW'(idx_r); of_wd = '0; of_ra = OW'(idx_r);
    st_we = 1'b0; st_wa = EW'(acc_r); st_wd = et; st_ra = EW'(eidx_r);
    pl_we = 1'b0; pl_wa = AW'(idx_r); pl_wd = '0; pl_ra = AW'(idx_r);
    rs_we = 1'b0; rs_wa = AW'(sp_r); rs_wd = VW'(idx_r); rs_ra = AW'(sp_r - 1'b1);
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (in_data.edge_valid) begin
            if (32'(etotal_r) < MAX_EDGES) begin
              es_we = 1'b1; etotal_nxt = etotal_r + 1'b1;
            end else ovf_nxt = 1'b1;
          end
          if (in_data.is_last) begin
            idx_nxt = '0; state_nxt = S_CLR;
          end
        end
      end
      S_CLR: begin
        of_we = 1'b1;
        if (idx_r < n_eff) begin dg_we = 1'b1; pl_we = 1'b1; end
        if (idx_r == n_eff) begin eidx_nxt = '0; state_nxt = S_DG_RD; end
        else idx_nxt = idx_r + 1'b1;
      end
      S_DG_RD: begin
        if (eidx_r == etotal_r) begin
          idx_nxt = '0; acc_nxt = '0; state_nxt = S_PS_RD;
        end else state_nxt = S_DG_WT;
      end
      S_DG_WT: begin
        // Edge word is now valid; read both counters it touches.
        dg_ra = AW'(et); of_ra = OW'({1'b0, ef} + 1'b1);
        state_nxt = S_DG_UP;
      end
      S_DG_UP: begin
        if (e_ok) begin
          dg_we = 1'b1; dg_wa = AW'(et); dg_wd = dg_rd + 1'b1;
          of_we = 1'b1; of_wa = OW'({1'b0, ef} + 1'b1); of_wd = of_rd + 1'b1;
        end
        eidx_nxt = eidx_r + 1'b1; state_nxt = S_DG_RD;
      end
      S_PS_RD: state_nxt = S_PS_WR;
      S_PS_WR: begin
        // Running sum makes entry v the start of bucket v.
        of_we = 1'b1; of_wd = acc_r + of_rd; acc_nxt = acc_r + of_rd;
        if (idx_r == n_eff) begin eidx_nxt = '0; state_nxt = S_BK_RD; end
        else begin idx_nxt = idx_r + 1'b1; state_nxt = S_PS_RD; end
      end
      S_BK_RD: begin
        if (eidx_r == etotal_r) begin
          idx_nxt = '0; sp_nxt = '0; state_nxt = S_RS_RD;
        end else state_nxt = S_BK_WT;
      end
      S_BK_WT: begin of_ra = OW'(ef); state_nxt = S_BK_UP; end
      S_BK_UP: begin
        if (e_ok) begin
          st_we = 1'b1; st_wa = EW'(of_rd);
          of_we = 1'b1; of_wa = OW'(ef); of_wd = of_rd + 1'b1;
        end
        eidx_nxt = eidx_r + 1'b1; state_nxt = S_BK_RD;
      end
      S_RS_RD: begin
        // After bucketing, entry v holds the end of bucket v, i.e. start of v+1.
        if (idx_r == n_eff) begin ord_nxt = '0; state_nxt = S_POP; end
        else state_nxt = S_RS_CK;
      end
      S_RS_CK: begin
        if (dg_rd == '0) begin rs_we = 1'b1; sp_nxt = sp_r + 1'b1; end
        idx_nxt = idx_r + 1'b1; state_nxt = S_RS_RD;
      end
      S_POP: begin
        if (sp_r == '0) begin idx_nxt = '0; best_nxt = '0; state_nxt = S_MX_RD; end
        else state_nxt = S_POP_WT;
      end
      S_POP_WT: begin sp_nxt = sp_r - 1'b1; state_nxt = S_POP2; end
      S_POP2: begin
        u_nxt = rs_rd; ord_nxt = ord_r + 1'b1; state_nxt = S_OFF;
      end
      S_OFF: begin
        // Bucket u spans [end of u-1, end of u); vertex 0 starts at zero.
        pl_ra = AW'(u_r); of_ra = OW'(u_r); state_nxt = S_OFF_WT;
      end
      S_OFF_WT: begin
        eend_nxt = ECW'(of_rd);
        cand_nxt = (pl_rd == dlp_pkg::PathCap) ? dlp_pkg::PathCap : pl_rd + 1'b1;
        of_ra = OW'(u_r) - 1'b1; state_nxt = S_OFF2;
      end
      S_OFF2: begin
        eidx_nxt = (u_r == '0) ? '0 : ECW'(of_rd);
        state_nxt = S_E_RD;
      end
      S_E_RD: begin
        if (eidx_r == eend_r) state_nxt = S_POP;
        else state_nxt = S_E_WT;
      end
      S_E_WT: state_nxt = S_W_RD;
      S_W_RD: begin
        w_nxt = st_rd; dg_ra = AW'(st_rd); pl_ra = AW'(st_rd); state_nxt = S_W_WT;
      end
      S_W_WT: begin
        // Keep the successor's address on both read ports so its data is there in the update state.
        dg_ra = AW'(w_r); pl_ra = AW'(w_r); state_nxt = S_W_UP;
      end
      S_W_UP: begin
        dg_we = 1'b1; dg_wa = AW'(w_r); dg_wd = dg_rd - 1'b1;
        if (dg_rd == (EW+1)'(1) && 32'(sp_r) < MAX_VERTICES) begin
          rs_we = 1'b1; rs_wd = w_r; sp_nxt = sp_r + 1'b1;
        end
        if (cand_r > pl_rd) begin pl_we = 1'b1; pl_wa = AW'(w_r); pl_wd = cand_r; end
        eidx_nxt = eidx_r + 1'b1; state_nxt = S_E_RD;
      end
      S_MX_RD: begin
        if (idx_r == n_eff) state_nxt = S_DONE;
        else state_nxt = S_MX_CK;
      end
      S_MX_CK: begin
        if (pl_rd > best_r) best_nxt = pl_rd;
        idx_nxt = idx_r + 1'b1; state_nxt = S_MX_RD;
      end
      S_DONE: begin
        if (!out_valid_r || out_acc) begin
          out_nxt.longest_path = best_r;
          out_nxt.cycle_found = ord_r < n_eff;
          out_nxt.edges_dropped = ovf_r;
          ov_nxt = 1'b1; etotal_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; vcount_r <= CW'(1024); etotal_r <= '0; ovf_r <= 1'b0;
      out_valid_r <= 1'b0; sp_r <= '0; ord_r <= '0;
    end else begin
      state_r <= state_nxt; etotal_r <= etotal_nxt; ovf_r <= ovf_nxt;
      out_valid_r <= ov_nxt; sp_r <= sp_nxt; ord_r <= ord_nxt;
      if (cfg_wr && paddr == RegVertexCount) vcount_r <= pwdata[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; eidx_r <= eidx_nxt; eend_r <= eend_nxt; acc_r <= acc_nxt;
    u_r <= u_nxt; w_r <= w_nxt; cand_r <= cand_nxt; best_r <= best_nxt; out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> !in_acc) else $error("beat accepted while busy");
  a_etotal_cap: assert property (@(posedge clk) disable iff (!rst_n)
    32'(etotal_r) <= MAX_EDGES) else $error("edge count beyond capacity");
  a_result_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && state_nxt == S_LOAD) |=> (out_valid && etotal_r == '0))
    else $error("result not raised after walk");
`endif
endmodule
